>>> design/owrs_pkg.sv
package owrs_pkg;

    // Request opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_PAIR  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_WRITE   = 3'd0;
    localparam logic [2:0] KIND_FOUND   = 3'd1;
    localparam logic [2:0] KIND_FAILED  = 3'd2;
    localparam logic [2:0] KIND_IGNORED = 3'd3;
    localparam logic [2:0] KIND_CLEARED = 3'd4;

    // Reflected CRC-8 polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;
    // Zero positions below this update the family discrepancy
    localparam logic [6:0] FAMILY_LIMIT = 7'd9;

    localparam int ROM_W = 64;

    typedef struct packed {
        logic [1:0] opcode;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } t_in_req;

    typedef struct packed {
        logic [2:0]       result_kind;
        logic             direction_bit;
        logic [ROM_W-1:0] rom_code;
        logic             crc_ok;
        logic             last_device;
        logic [3:0]       family_discrepancy_out;
    } t_out_res;

endpackage

>>> design/one_wire_rom_search_top.sv
// Search-ROM enumeration engine: one request in, one result out.
// The result is registered and is valid in the cycle after the request is accepted.
// Throughput: 1 request per cycle unless a held result is stalled; the whole bit
// step (direction choice, ROM bit update, one CRC shift) sits between the state and result registers.
// Reset (i_rst_n low, synchronous): search state returns to its cleared values
// (bit position 1, all else zero) and the result register empties.
module one_wire_rom_search_top import owrs_pkg::*; #(
    parameter int ROM_BYTES = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    // Bits covered by a pass, bits covered by the CRC, and where the check
    // byte sits in the ROM register.
    localparam logic [6:0] TOTAL_BITS = 7'(ROM_BYTES * 8);
    localparam logic [6:0] CRC_BITS   = 7'((ROM_BYTES - 1) * 8);
    localparam int         CHECK_LSB  = (ROM_BYTES - 1) * 8;

    // Search state
    logic [ROM_W-1:0] r_rom,    n_rom;
    logic [6:0]       r_prior,  n_prior;
    logic             r_found,  n_found;
    logic [3:0]       r_family, n_family;
    logic [6:0]       r_bitpos, n_bitpos;
    logic [6:0]       r_plz,    n_plz;
    logic [7:0]       r_crc,    n_crc;
    logic             r_active, n_active;

    // Result register
    logic     r_out_valid;
    t_out_res r_out, n_out;

    logic accept;

    // Bit step helpers
    logic [5:0]       w_idx;
    logic             w_same;
    logic             w_dir;
    logic [ROM_W-1:0] w_rom_upd;
    logic [7:0]       w_crc_upd;
    logic             w_mix;
    logic [6:0]       w_bitpos_inc;
    logic [6:0]       w_plz_upd;
    logic [3:0]       w_family_upd;

    // Stall the request side only while a held result cannot move on.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Direction choice: a clean bit follows the bus; on a discrepancy, repeat
    // the earlier path below the last discrepancy, take 1 at it, 0 beyond.
    always_comb begin
        w_idx  = 6'(r_bitpos - 7'd1);
        w_same = (i_in_data.id_bit == i_in_data.complement_bit);
        if (!w_same) begin
            w_dir = i_in_data.id_bit;
        end else if (r_bitpos < r_prior) begin
            w_dir = r_rom[w_idx];
        end else begin
            w_dir = (r_bitpos == r_prior);
        end

        w_rom_upd = (r_rom & ~(ROM_W'(1) << w_idx)) | (ROM_W'(w_dir) << w_idx);

        // One bit-serial CRC shift, only over the bytes ahead of the check byte.
        w_mix = r_crc[0] ^ w_dir;
        if ({1'b0, w_idx} < CRC_BITS) begin
            w_crc_upd = {1'b0, r_crc[7:1]} ^ (w_mix ? CRC_POLY : 8'd0);
        end else begin
            w_crc_upd = r_crc;
        end

        w_bitpos_inc = r_bitpos + 7'd1;

        // Record a zero taken on a discrepancy.
        w_plz_upd    = r_plz;
        w_family_upd = r_family;
        if (w_same && !w_dir) begin
            w_plz_upd = r_bitpos;
            if (r_bitpos < FAMILY_LIMIT) begin
                w_family_upd = r_bitpos[3:0];
            end
        end
    end

    always_comb begin
        n_rom    = r_rom;
        n_prior  = r_prior;
        n_found  = r_found;
        n_family = r_family;
        n_bitpos = r_bitpos;
        n_plz    = r_plz;
        n_crc    = r_crc;
        n_active = r_active;
        n_out             = '0;
        n_out.result_kind = KIND_IGNORED;

        case (i_in_data.opcode)
            OP_CLEAR: begin
                n_rom    = '0;
                n_prior  = '0;
                n_found  = 1'b0;
                n_family = '0;
                n_bitpos = 7'd1;
                n_plz    = '0;
                n_crc    = '0;
                n_active = 1'b0;
                n_out.result_kind = KIND_CLEARED;
            end
            OP_START: begin
                if (r_found || !i_in_data.presence) begin
                    // No device answered, or enumeration already finished.
                    n_prior  = '0;
                    n_found  = 1'b0;
                    n_family = '0;
                    n_active = 1'b0;
                    n_out.result_kind = KIND_FAILED;
                end else begin
                    // Restart from bit 1; any pass in progress is dropped.
                    n_bitpos = 7'd1;
                    n_plz    = '0;
                    n_crc    = '0;
                    n_active = 1'b1;
                end
            end
            OP_PAIR: begin
                if (r_active) begin
                    if (i_in_data.id_bit && i_in_data.complement_bit) begin
                        // Nobody drove the bus for this bit.
                        n_prior  = '0;
                        n_found  = 1'b0;
                        n_family = '0;
                        n_active = 1'b0;
                        n_out.result_kind = KIND_FAILED;
                    end else begin
                        n_rom    = w_rom_upd;
                        n_crc    = w_crc_upd;
                        n_bitpos = w_bitpos_inc;
                        n_plz    = w_plz_upd;
                        n_family = w_family_upd;
                        n_out.direction_bit = w_dir;
                        if (w_bitpos_inc <= TOTAL_BITS) begin
                            n_out.result_kind = KIND_WRITE;
                        end else begin
                            // Final bit: close the pass.
                            n_active = 1'b0;
                            n_prior  = w_plz_upd;
                            if (w_plz_upd == '0) begin
                                n_found = 1'b1;
                            end
                            if (w_rom_upd[7:0] == 8'd0) begin
                                n_prior  = '0;
                                n_found  = 1'b0;
                                n_family = '0;
                                n_out.result_kind = KIND_FAILED;
                            end else begin
                                n_out.result_kind = KIND_FOUND;
                                n_out.crc_ok      = (w_rom_upd[CHECK_LSB +: 8] == w_crc_upd);
                                n_out.last_device = (w_plz_upd == '0) | r_found;
                            end
                        end
                    end
                end
            end
            default: begin
                // Unused opcode: acknowledge, no state change.
                n_out.result_kind = KIND_IGNORED;
            end
        endcase

        n_out.rom_code               = n_rom;
        n_out.family_discrepancy_out = n_family;
    end

    // Search state advances on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom    <= '0;
            r_prior  <= '0;
            r_found  <= 1'b0;
            r_family <= '0;
            r_bitpos <= 7'd1;
            r_plz    <= '0;
            r_crc    <= '0;
            r_active <= 1'b0;
        end else if (accept) begin
            r_rom    <= n_rom;
            r_prior  <= n_prior;
            r_found  <= n_found;
            r_family <= n_family;
            r_bitpos <= n_bitpos;
            r_plz    <= n_plz;
            r_crc    <= n_crc;
            r_active <= n_active;
        end
    end

    // Result register: load on accept, drop once taken downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule
